// ===== hw/rtl/prm_pkg.sv =====
`default_nettype none
package prm_pkg;

	localparam int HDR_BYTES_DEF    = 54;
	localparam int PORT_ENTRIES_DEF = 4;
	localparam int NUM_PORT_REGS    = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TOS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PORT_A = 3'd1;

	localparam logic [7:0]  TOS_RESET = 8'hFF;
	localparam logic [15:0] PORT_RESET [NUM_PORT_REGS] = '{16'd5004, 16'd5005,
		16'd60000, 16'd60001};

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;

	// byte offsets from the start of the frame
	localparam int IDX_ETH_HI   = 12;
	localparam int IDX_ETH_LO   = 13;
	localparam int IDX_IP_FIRST = 14;
	localparam int IDX_TOS      = 15;
	localparam int IDX_PROTO    = 23;
	localparam int IDX_CSUM_HI  = 24;
	localparam int IDX_CSUM_LO  = 25;
	localparam int IDX_IP_LAST  = 33;
	localparam int IDX_DPORT_HI = 36;
	localparam int IDX_DPORT_LO = 37;
	localparam int IDX_UDP_END  = 41;
	localparam int IDX_TCP_END  = 53;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_UDP,
		KIND_TCP
	} prm_kind_t;

	typedef enum logic [1:0] {
		ST_BUF,
		ST_RD,
		ST_OUT,
		ST_PASS
	} prm_state_t;

	typedef struct packed {
		logic        flush;
		logic        hit;
		logic [15:0] csum;
	} prm_dec_t;

endpackage
`default_nettype wire

// ===== hw/rtl/prm_hdr_mem.sv =====
`default_nettype none
module prm_hdr_mem import prm_pkg::*; #(
	parameter int DEPTH = HDR_BYTES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [7:0]               wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [7:0]               rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/prm_parse.sv =====
`default_nettype none
module prm_parse import prm_pkg::*; #(
	parameter int POS_W     = 6,
	parameter int PORT_REGS = NUM_PORT_REGS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             acc,
	input  wire logic [POS_W-1:0] pos,
	input  wire logic [7:0]       data,
	input  wire logic             clr,
	input  wire logic [7:0]       tos,
	input  wire logic [15:0]      ports [PORT_REGS],
	output prm_dec_t              dec
);

	logic [7:0]  eth_hi_q;
	logic [7:0]  proto_q;
	logic [15:0] dport_q;
	prm_kind_t   kind_q;
	logic [15:0] sum_q;

	logic        in_ip;
	logic [7:0]  sum_byte;
	logic [15:0] addend;
	logic [16:0] sum_raw;
	logic [15:0] sum_d;
	logic        port_hit;

	assign in_ip = (pos >= POS_W'(IDX_IP_FIRST)) && (pos <= POS_W'(IDX_IP_LAST));

	always_comb begin
		// TOS counts as the new value, checksum field as zero
		priority if (pos == POS_W'(IDX_TOS)) begin
			sum_byte = tos;
		end else if (pos == POS_W'(IDX_CSUM_HI) || pos == POS_W'(IDX_CSUM_LO)) begin
			sum_byte = 8'h00;
		end else begin
			sum_byte = data;
		end
		addend  = pos[0] ? {8'h00, sum_byte} : {sum_byte, 8'h00};
		sum_raw = {1'b0, sum_q} + {1'b0, addend};
		// end-around carry
		sum_d   = sum_raw[15:0] + {15'd0, sum_raw[16]};
	end

	always_comb begin
		port_hit = 1'b0;
		for (int k = 0; k < PORT_REGS; k++) begin
			if (ports[k] == dport_q) begin
				port_hit = 1'b1;
			end
		end
		port_hit = port_hit && (dport_q != 16'd0);
	end

	always_comb begin
		dec.flush = 1'b0;
		dec.hit   = 1'b0;
		dec.csum  = ~sum_q;
		if (acc) begin
			priority if (pos == POS_W'(IDX_ETH_LO)) begin
				dec.flush = ({eth_hi_q, data} != ETHERTYPE_IPV4);
			end else if (pos == POS_W'(IDX_IP_LAST)) begin
				dec.flush = (proto_q != PROTO_UDP) && (proto_q != PROTO_TCP);
			end else if ((kind_q == KIND_UDP && pos == POS_W'(IDX_UDP_END)) ||
					(kind_q == KIND_TCP && pos == POS_W'(IDX_TCP_END))) begin
				dec.flush = 1'b1;
				dec.hit   = port_hit;
			end else begin
				dec.flush = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_NONE;
			sum_q  <= 16'd0;
		end else if (clr) begin
			kind_q <= KIND_NONE;
			sum_q  <= 16'd0;
		end else if (acc) begin
			if (in_ip) begin
				sum_q <= sum_d;
			end
			if (pos == POS_W'(IDX_IP_LAST)) begin
				priority if (proto_q == PROTO_UDP) begin
					kind_q <= KIND_UDP;
				end else if (proto_q == PROTO_TCP) begin
					kind_q <= KIND_TCP;
				end else begin
					kind_q <= KIND_NONE;
				end
			end
		end
	end

	// header fields, captured as they go by
	always_ff @(posedge clk) begin
		if (acc) begin
			if (pos == POS_W'(IDX_ETH_HI)) begin
				eth_hi_q <= data;
			end
			if (pos == POS_W'(IDX_PROTO)) begin
				proto_q <= data;
			end
			if (pos == POS_W'(IDX_DPORT_HI)) begin
				dport_q[15:8] <= data;
			end
			if (pos == POS_W'(IDX_DPORT_LO)) begin
				dport_q[7:0] <= data;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/port_match_tos_remarker.sv =====
// A held header byte leaves through ST_RD (buffer memory read), then ST_OUT (output
// register load), after the deciding beat or the previous flushed byte; after the
// decision, bytes pass through the output register. Input is taken at 1 byte per
// cycle while buffering, or while passing if the output is not stalled; during the
// header flush no input is taken. Reset: asynchronous, active low; state, control
// and configuration registers reset, data registers and the header memory do not.
`default_nettype none
module port_match_tos_remarker import prm_pkg::*; #(
	parameter int HEADER_BUFFER_BYTES = HDR_BYTES_DEF,
	parameter int PORT_TABLE_ENTRIES  = PORT_ENTRIES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            in_byte,
	input  wire logic                  in_last,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 out_byte,
	output logic                       out_last,
	output logic                       remarked
);

	localparam int ADDR_W    = $clog2(HEADER_BUFFER_BYTES);
	localparam int POS_W     = $clog2(HEADER_BUFFER_BYTES + 1);
	localparam int PORT_REGS = (PORT_TABLE_ENTRIES < NUM_PORT_REGS) ?
		PORT_TABLE_ENTRIES : NUM_PORT_REGS;

	logic [7:0]  tos_q;
	logic [15:0] port_q [PORT_REGS];

	prm_state_t        state_q, state_d;
	logic [POS_W-1:0]  pos_q;
	logic [ADDR_W-1:0] rd_q;
	logic              last_q;
	logic              matched_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic              remarked_q;

	logic       out_free;
	logic       in_acc;
	logic       buf_acc;
	logic       pass_acc;
	logic       mem_re;
	logic       out_load;
	logic       final_rd;
	logic       frame_end;
	logic [7:0] mem_rdata;
	logic [7:0] flush_byte;
	prm_dec_t   dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tos_q <= TOS_RESET;
			for (int k = 0; k < PORT_REGS; k++) begin
				port_q[k] <= PORT_RESET[k];
			end
		end else if (cfg_we) begin
			if (cfg_idx == CFG_TOS) begin
				tos_q <= cfg_wdata[7:0];
			end
			for (int k = 0; k < PORT_REGS; k++) begin
				if (cfg_idx == CFG_PORT_A + CFG_IDX_W'(k)) begin
					port_q[k] <= cfg_wdata;
				end
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;
	assign buf_acc  = in_acc && (state_q == ST_BUF);
	assign pass_acc = in_acc && (state_q == ST_PASS);
	assign final_rd = (POS_W'(rd_q) + POS_W'(1)) == pos_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_BUF: begin
				if (buf_acc && (dec.flush || in_last)) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					if (!final_rd) begin
						state_d = ST_RD;
					end else if (last_q) begin
						state_d = ST_BUF;
					end else begin
						state_d = ST_PASS;
					end
				end
			end
			ST_PASS: begin
				if (pass_acc && in_last) begin
					state_d = ST_BUF;
				end
			end
			default: begin
				state_d = ST_BUF;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		mem_re    = 1'b0;
		out_load  = 1'b0;
		frame_end = 1'b0;
		unique case (state_q)
			ST_BUF: begin
				in_ready = 1'b1;
			end
			ST_RD: begin
				mem_re = 1'b1;
			end
			ST_OUT: begin
				out_load  = out_free;
				frame_end = out_free && final_rd && last_q;
			end
			ST_PASS: begin
				in_ready  = out_free;
				frame_end = pass_acc && in_last;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_comb begin
		flush_byte = mem_rdata;
		if (matched_q) begin
			if (rd_q == ADDR_W'(IDX_TOS)) begin
				flush_byte = tos_q;
			end else if (rd_q == ADDR_W'(IDX_CSUM_HI)) begin
				flush_byte = dec.csum[15:8];
			end else if (rd_q == ADDR_W'(IDX_CSUM_LO)) begin
				flush_byte = dec.csum[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BUF;
			pos_q       <= '0;
			rd_q        <= '0;
			last_q      <= 1'b0;
			matched_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (buf_acc) begin
				pos_q <= pos_q + POS_W'(1);
				if (dec.flush || in_last) begin
					last_q    <= in_last;
					matched_q <= dec.hit;
					rd_q      <= '0;
				end
			end
			if (out_load) begin
				if (final_rd) begin
					pos_q <= '0;
				end else begin
					rd_q <= rd_q + ADDR_W'(1);
				end
			end
			if (frame_end) begin
				matched_q <= 1'b0;
			end
			if (out_load || pass_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte_q <= flush_byte;
			out_last_q <= last_q && final_rd;
			remarked_q <= matched_q;
		end else if (pass_acc) begin
			out_byte_q <= in_byte;
			out_last_q <= in_last;
			remarked_q <= matched_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign remarked  = remarked_q;

	prm_hdr_mem #(
		.DEPTH(HEADER_BUFFER_BYTES)
	) u_mem (
		.clk   (clk),
		.we    (buf_acc),
		.waddr (pos_q[ADDR_W-1:0]),
		.wdata (in_byte),
		.re    (mem_re),
		.raddr (rd_q),
		.rdata (mem_rdata)
	);

	prm_parse #(
		.POS_W     (POS_W),
		.PORT_REGS (PORT_REGS)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (buf_acc),
		.pos    (pos_q),
		.data   (in_byte),
		.clr    (frame_end),
		.tos    (tos_q),
		.ports  (port_q),
		.dec    (dec)
	);

`ifndef ASSERT_OFF
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(HEADER_BUFFER_BYTES))
		else $error("header position past buffer");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_OUT) |-> (POS_W'(rd_q) < pos_q))
		else $error("flush read beyond held bytes");

	a_rd_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |=> (state_q == ST_OUT))
		else $error("memory read not followed by output load");

	a_no_take_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_OUT) |-> !in_ready)
		else $error("input taken during header flush");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import prm_pkg::*;

	localparam int SETTLE_CYCLES   = 150;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int BYTES_PER_PHASE = 10;
	localparam int HOLD_CYCLES     = 400;
	localparam int IP_HDR_BYTES    = IDX_IP_LAST - IDX_IP_FIRST + 1;

	localparam int REG_TOS          = int'(CFG_TOS);
	localparam int REG_PORT_A       = int'(CFG_PORT_A);
	localparam int REG_PORT_D       = REG_PORT_A + NUM_PORT_REGS - 1;
	localparam int REG_UNUSED_FIRST = REG_PORT_D + 1;
	localparam int REG_UNUSED_LAST  = (1 << CFG_IDX_W) - 1;

	localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
	localparam logic [7:0]  PROTO_ICMP     = 8'd1;

	typedef struct {
		logic [7:0] b;
		logic       last;
		logic       rem;
	} out_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            in_byte = '0;
	logic                  in_last = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            out_byte;
	logic                  out_last;
	logic                  remarked;

	port_match_tos_remarker dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
		.out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
		.out_last(out_last), .remarked(remarked)
	);

	always #5 clk = ~clk;

	// shadow of the block: registers and per-frame header state
	logic [7:0]  tos_reg = TOS_RESET;
	logic [15:0] port_tbl [NUM_PORT_REGS] = PORT_RESET;
	logic [7:0]  hdr_buf [HDR_BYTES_DEF];
	int          hdr_pos = 0;
	logic        passing = 1'b0;
	prm_kind_t   kind = KIND_NONE;
	logic        hit_frame = 1'b0;

	out_beat_t   pending_bytes [$];
	logic [7:0]  frame_buf [$];
	int          mismatches = 0;
	int          send_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          rx_hold_req = 0;
	int          rx_hold_left = 0;
	int          quiet_cycles = 0;

	function automatic void start_frame();
		hdr_pos = 0;
		passing = 1'b0;
		kind = KIND_NONE;
		hit_frame = 1'b0;
	endfunction

	function automatic logic port_matches(input logic [15:0] port);
		if (port == 16'd0)
			return 1'b0;
		for (int n = 0; n < NUM_PORT_REGS; n++)
			if (port_tbl[n] == port)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic void rewrite_ip_header();
		logic [31:0] sum;
		logic [15:0] csum;
		hdr_buf[IDX_TOS] = tos_reg;
		hdr_buf[IDX_CSUM_HI] = 8'h00;
		hdr_buf[IDX_CSUM_LO] = 8'h00;
		sum = 32'd0;
		for (int i = 0; i < IP_HDR_BYTES; i += 2) begin
			sum += {16'd0, hdr_buf[IDX_IP_FIRST + i], hdr_buf[IDX_IP_FIRST + i + 1]};
			if (sum > 32'hFFFF)
				sum -= 32'hFFFF;
		end
		csum = ~sum[15:0];
		hdr_buf[IDX_CSUM_HI] = csum[15:8];
		hdr_buf[IDX_CSUM_LO] = csum[7:0];
		hit_frame = 1'b1;
	endfunction

	function automatic void push_beat(input logic [7:0] b, input logic l);
		out_beat_t beat;
		beat.b = b;
		beat.last = l;
		beat.rem = hit_frame;
		pending_bytes.push_back(beat);
	endfunction

	function automatic void flush_header(input logic l);
		for (int i = 0; i < hdr_pos; i++)
			push_beat(hdr_buf[i], l && (i == hdr_pos - 1));
		if (l)
			start_frame();
		else
			passing = 1'b1;
	endfunction

	function automatic void predict_frame_byte(input logic [7:0] b, input logic l);
		logic decide;
		if (passing) begin
			push_beat(b, l);
			if (l)
				start_frame();
			return;
		end
		decide = 1'b0;
		hdr_buf[hdr_pos] = b;
		hdr_pos++;
		if (hdr_pos == IDX_ETH_LO + 1) begin
			decide = {hdr_buf[IDX_ETH_HI], hdr_buf[IDX_ETH_LO]} != ETHERTYPE_IPV4;
		end else if (hdr_pos == IDX_IP_LAST + 1) begin
			if (hdr_buf[IDX_PROTO] == PROTO_UDP)
				kind = KIND_UDP;
			else if (hdr_buf[IDX_PROTO] == PROTO_TCP)
				kind = KIND_TCP;
			else
				decide = 1'b1;
		end else if ((kind == KIND_UDP && hdr_pos == IDX_UDP_END + 1) ||
				(kind == KIND_TCP && hdr_pos == IDX_TCP_END + 1)) begin
			if (port_matches({hdr_buf[IDX_DPORT_HI], hdr_buf[IDX_DPORT_LO]}))
				rewrite_ip_header();
			decide = 1'b1;
		end
		if (decide || l)
			flush_header(l);
	endfunction

	// receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (rx_hold_req > 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin : check_output
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected beat: byte %02h last %0b remarked %0b",
					$time, out_byte, out_last, remarked);
				mismatches++;
			end else begin
				want = pending_bytes.pop_front();
				if (want.b !== out_byte || want.last !== out_last ||
						want.rem !== remarked) begin
					$display({"%0t: mismatch: expected byte %02h last %0b remarked %0b,",
						" got byte %02h last %0b remarked %0b"},
						$time, want.b, want.last, want.rem, out_byte, out_last,
						remarked);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic l);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= l;
		do @(posedge clk); while (!in_ready);
		predict_frame_byte(b, l);
	endtask

	task automatic send_frame();
		foreach (frame_buf[i])
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input int idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx[CFG_IDX_W-1:0];
		cfg_wdata <= val;
		@(posedge clk);
		if (idx == REG_TOS)
			tos_reg = val[7:0];
		else if (idx >= REG_PORT_A && idx <= REG_PORT_D)
			port_tbl[idx - REG_PORT_A] = val;
	endtask

	task automatic end_reg_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// random bytes with ethertype, protocol and destination port placed where they fit
	task automatic make_frame(input logic [15:0] etype, input logic [7:0] proto,
			input logic [15:0] dport, input int len);
		frame_buf.delete();
		repeat (len) frame_buf.push_back(8'($urandom_range(255)));
		if (len > IDX_ETH_HI)   frame_buf[IDX_ETH_HI] = etype[15:8];
		if (len > IDX_ETH_LO)   frame_buf[IDX_ETH_LO] = etype[7:0];
		if (len > IDX_PROTO)    frame_buf[IDX_PROTO] = proto;
		if (len > IDX_DPORT_HI) frame_buf[IDX_DPORT_HI] = dport[15:8];
		if (len > IDX_DPORT_LO) frame_buf[IDX_DPORT_LO] = dport[7:0];
	endtask

	task automatic random_frame();
		int sel;
		int hdr_end;
		int len;
		logic [7:0] proto;
		logic [15:0] dport;
		logic [15:0] etype;
		sel = $urandom_range(99);
		proto = $urandom_range(1) ? PROTO_UDP : PROTO_TCP;
		hdr_end = (proto == PROTO_UDP) ? IDX_UDP_END + 1 : IDX_TCP_END + 1;
		dport = ($urandom_range(9) < 7) ? port_tbl[$urandom_range(NUM_PORT_REGS - 1)]
			: 16'($urandom_range(16'hFFFF));
		etype = ETHERTYPE_IPV4;
		if (sel < 55) begin
			len = hdr_end + $urandom_range(0, 6);
		end else if (sel < 67) begin
			// cut off before the port decision
			len = $urandom_range(1, hdr_end - 1);
		end else if (sel < 77) begin
			etype = 16'($urandom_range(16'hFFFF));
			if (etype == ETHERTYPE_IPV4)
				etype = ETHERTYPE_IPV6;
			len = $urandom_range(IDX_ETH_LO + 1, 24);
		end else if (sel < 87) begin
			proto = 8'($urandom_range(255));
			if (proto == PROTO_UDP || proto == PROTO_TCP)
				proto = PROTO_ICMP;
			len = $urandom_range(IDX_IP_LAST + 1, 40);
		end else begin
			etype = ($urandom_range(3) == 0) ? ETHERTYPE_IPV4 : 16'($urandom_range(16'hFFFF));
			proto = 8'($urandom_range(255));
			dport = 16'($urandom_range(16'hFFFF));
			len = $urandom_range(1, 60);
		end
		make_frame(etype, proto, dport, len);
	endtask

	task automatic test_default_registers();
		send_idle_pct = 0;
		rx_stall_pct = 0;
		// decision lands on the last byte, except in the one-byte frame
		make_frame(ETHERTYPE_IPV4, PROTO_TCP, PORT_RESET[3], IDX_TCP_END + 1);
		send_frame();
		make_frame(ETHERTYPE_IPV6, PROTO_UDP, PORT_RESET[0], IDX_ETH_LO + 1);
		send_frame();
		make_frame(ETHERTYPE_IPV4, PROTO_ICMP, PORT_RESET[0], IDX_IP_LAST + 1);
		send_frame();
		make_frame(ETHERTYPE_IPV4, PROTO_UDP, PORT_RESET[0], 1);
		send_frame();
		wait_idle();
	endtask

	task automatic test_register_extremes();
		set_reg(REG_TOS, 16'hFF00);
		set_reg(REG_PORT_A, 16'h0000);
		set_reg(REG_PORT_A + 1, 16'hFFFF);
		set_reg(REG_PORT_A + 2, 16'h5555);
		set_reg(REG_PORT_D, 16'hAAAA);
		// unknown indexes must leave the table alone
		for (int idx = REG_UNUSED_FIRST; idx <= REG_UNUSED_LAST; idx++)
			set_reg(idx, 16'h1234);
		end_reg_writes();
		make_frame(ETHERTYPE_IPV4, PROTO_UDP, 16'h0000, IDX_UDP_END + 1);
		send_frame();
		make_frame(ETHERTYPE_IPV4, PROTO_UDP, 16'hFFFF, IDX_UDP_END + 1);
		send_frame();
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int send_pct [4] = '{0, 57, 0, 30};
		int rx_pct [4] = '{0, 0, 57, 30};
		int sent;
		for (int ph = 0; ph < 4; ph++) begin
			set_reg(REG_TOS, 16'($urandom_range(16'hFFFF)));
			for (int idx = REG_PORT_A; idx <= REG_PORT_D; idx++)
				set_reg(idx, 16'($urandom_range(16'hFFFF)));
			set_reg($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST),
				16'($urandom_range(16'hFFFF)));
			end_reg_writes();
			send_idle_pct = send_pct[ph];
			rx_stall_pct = rx_pct[ph];
			sent = 0;
			while (sent < BYTES_PER_PHASE) begin
				random_frame();
				send_frame();
				sent += frame_buf.size();
			end
			wait_idle();
		end
	endtask

	task automatic test_output_hold();
		send_idle_pct = 0;
		rx_stall_pct = 0;
		// hold the output long enough that the flush stalls and the next frame waits
		rx_hold_req = HOLD_CYCLES;
		make_frame(ETHERTYPE_IPV4, PROTO_UDP, port_tbl[0], 24);
		send_frame();
		make_frame(ETHERTYPE_IPV4, PROTO_UDP, port_tbl[0], 1);
		send_frame();
		wait_idle();
	endtask

	initial begin
		start_frame();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_default_registers();
		test_register_extremes();
		test_random_traffic();
		test_output_hold();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
